>>> rtl/mhd_pkg.sv
package mhd_pkg;

    localparam int HDR_BYTES = 28;
    localparam int CNT_W     = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int OFS_TYPE    = 2;
    localparam int OFS_FLAGS   = 3;
    localparam int OFS_ID      = 4;
    localparam int OFS_THREAD  = 8;
    localparam int OFS_PREV    = 12;
    localparam int OFS_SENDER  = 16;
    localparam int OFS_TARGET  = 18;
    localparam int OFS_SERVICE = 20;
    localparam int OFS_EXPIRY  = 24;
    localparam int OFS_LEN     = 26;

    localparam int RES_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_PAYLOAD   = 3'd0,
        ST_OK        = 3'd1,
        ST_SHORT     = 3'd2,
        ST_MAGIC     = 3'd3,
        ST_VERSION   = 3'd4,
        ST_TOO_LARGE = 3'd5,
        ST_TRUNCATED = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        REG_MAGIC       = 2'd0,
        REG_VERSION     = 2'd1,
        REG_MAX_PAYLOAD = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] body_length;
        logic [15:0] expiry_seconds;
        logic [31:0] service_word;
        logic [31:0] node_pair;
        logic [31:0] previous_ident;
        logic [31:0] thread_ident;
        logic [31:0] msg_ident;
        logic [7:0]  flags;
        logic [7:0]  msg_type;
        status_t     status;
    } result_t;

endpackage

>>> rtl/mhd_res_fifo.sv
module mhd_res_fifo
    import mhd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_a,
    input  result_t data_a,
    input  logic    push_b,
    input  result_t data_b,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W_F = $clog2(RES_DEPTH + 1);

    result_t             mem [RES_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_F-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]    wr_ptr_b;
    logic                pop;
    logic [CNT_W_F-1:0]  n_push;

    assign wr_ptr_b  = wr_ptr_reg + PTR_W'(1);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // two free entries: a final payload word plus its verdict
    assign room      = (count_reg <= CNT_W_F'(RES_DEPTH - 2));

    always_comb
    begin
        n_push      = CNT_W_F'(push_a) + CNT_W_F'(push_b);
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + n_push - CNT_W_F'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem[wr_ptr_reg] <= data_a;
        end
        if (push_b)
        begin
            mem[wr_ptr_b] <= data_b;
        end
    end

    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push_b |-> push_a)
        else $error("second word pushed without first");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_a |-> count_reg <= CNT_W_F'(RES_DEPTH - 2))
        else $error("push without room");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push_a) |=> count_reg == $past(count_reg) - CNT_W_F'(1))
        else $error("count lost track of a pop");

endmodule

>>> rtl/message_header_deframer_top.sv
// Message header deframer.
// Slave stream: one received byte per word on s_axis_tdata, s_axis_tlast on the
// final byte of a buffer. The first 28 bytes are a little-endian header.
// Master stream: status on m_axis_tuser (0 payload byte, 1 ok, 2 short,
// 3 bad magic, 4 bad version, 5 too large, 6 truncated), other fields on
// m_axis_tdata. Payload bytes are forwarded once the header checks pass, up
// to the declared length; the verdict word follows the final byte. A
// consumer drops forwarded payload unless the verdict is ok.
// APB port: magic_value at 0x0, version_value at 0x4, max_payload at 0x8;
// write only while the block is idle.
// Result words enter the result queue as their byte is taken. Throughput is
// one byte per cycle unless the receiver stalls; the 4-word result queue needs
// two free words to take a byte (a final payload byte yields two words).
// Reset clears the byte count, header status, queue and registers to their
// defaults. When the receiver stalls the queue fills and s_axis_tready falls
// once fewer than two words are free; nothing is lost.
module message_header_deframer_top
    import mhd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] msg_type, [15:8] flags, [47:16] msg_ident, [79:48] thread_ident,
    // [111:80] previous_ident, [143:112] node_pair, [175:144] service_word,
    // [191:176] expiry_seconds, [207:192] body_length, [215:208] payload_byte
    output logic [215:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // [2:0] status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [7:0]       magic_reg;
    logic [7:0]       version_reg;
    logic [15:0]      max_payload_reg;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic             hdr_good_reg, hdr_good_next;
    logic [7:0]       hdr_reg [HDR_BYTES];
    logic [7:0]       hdr_eff [HDR_BYTES];

    logic             accept;
    logic             in_hdr;
    logic             fwd;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] body_pos;
    logic [15:0]      len_reg;
    logic [15:0]      len_eff;
    logic             checks_ok;
    status_t          verdict_st;
    result_t          pay_item, verdict_item, item_a, item_b;
    logic             push_a, push_b, room;
    result_t          head;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    // APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAGIC:       prdata = {24'd0, magic_reg};
            REG_VERSION:     prdata = {24'd0, version_reg};
            REG_MAX_PAYLOAD: prdata = {16'd0, max_payload_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg       <= 8'd0;
            version_reg     <= 8'd1;
            max_payload_reg <= 16'd256;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MAGIC:       magic_reg       <= pwdata[7:0];
                REG_VERSION:     version_reg     <= pwdata[7:0];
                REG_MAX_PAYLOAD: max_payload_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // byte path
    assign accept = s_axis_tvalid && s_axis_tready;
    assign in_hdr = byte_cnt_reg < CNT_W'(HDR_BYTES);
    assign cnt_inc = (byte_cnt_reg == CNT_MAX) ? byte_cnt_reg
                                               : byte_cnt_reg + CNT_W'(1);
    assign body_pos = byte_cnt_reg - CNT_W'(HDR_BYTES);
    assign len_reg  = {hdr_reg[OFS_LEN+1], hdr_reg[OFS_LEN]};

    // header as seen including the byte now arriving
    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            hdr_eff[i] = (byte_cnt_reg == CNT_W'(i)) ? s_axis_tdata : hdr_reg[i];
        end
    end

    assign len_eff   = {hdr_eff[OFS_LEN+1], hdr_eff[OFS_LEN]};
    assign checks_ok = (hdr_eff[0] == magic_reg) && (hdr_eff[1] == version_reg)
                    && (len_eff <= max_payload_reg);

    assign fwd = hdr_good_reg && !in_hdr && (byte_cnt_reg != CNT_MAX)
              && (body_pos < {1'b0, len_reg});

    always_comb
    begin
        if (cnt_inc < CNT_W'(HDR_BYTES))
            verdict_st = ST_SHORT;
        else if (hdr_eff[0] != magic_reg)
            verdict_st = ST_MAGIC;
        else if (hdr_eff[1] != version_reg)
            verdict_st = ST_VERSION;
        else if (len_eff > max_payload_reg)
            verdict_st = ST_TOO_LARGE;
        else if ({1'b0, cnt_inc} < (18'(HDR_BYTES) + {2'b00, len_eff}))
            verdict_st = ST_TRUNCATED;
        else
            verdict_st = ST_OK;
    end

    always_comb
    begin
        pay_item              = '0;
        pay_item.status       = ST_PAYLOAD;
        pay_item.payload_byte = s_axis_tdata;

        verdict_item        = '0;
        verdict_item.status = verdict_st;
        if (verdict_st == ST_OK)
        begin
            verdict_item.msg_type       = hdr_eff[OFS_TYPE];
            verdict_item.flags          = hdr_eff[OFS_FLAGS];
            verdict_item.msg_ident      = {hdr_eff[OFS_ID+3], hdr_eff[OFS_ID+2],
                                           hdr_eff[OFS_ID+1], hdr_eff[OFS_ID]};
            verdict_item.thread_ident   = {hdr_eff[OFS_THREAD+3], hdr_eff[OFS_THREAD+2],
                                           hdr_eff[OFS_THREAD+1], hdr_eff[OFS_THREAD]};
            verdict_item.previous_ident = {hdr_eff[OFS_PREV+3], hdr_eff[OFS_PREV+2],
                                           hdr_eff[OFS_PREV+1], hdr_eff[OFS_PREV]};
            // sender in the high half, target in the low half
            verdict_item.node_pair      = {hdr_eff[OFS_SENDER+1], hdr_eff[OFS_SENDER],
                                           hdr_eff[OFS_TARGET+1], hdr_eff[OFS_TARGET]};
            verdict_item.service_word   = {hdr_eff[OFS_SERVICE+3], hdr_eff[OFS_SERVICE+2],
                                           hdr_eff[OFS_SERVICE+1], hdr_eff[OFS_SERVICE]};
            verdict_item.expiry_seconds = {hdr_eff[OFS_EXPIRY+1], hdr_eff[OFS_EXPIRY]};
            verdict_item.body_length    = len_eff;
        end

        item_a = fwd ? pay_item : verdict_item;
        item_b = verdict_item;
        push_a = accept && (fwd || s_axis_tlast);
        push_b = accept && fwd && s_axis_tlast;
    end

    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        hdr_good_next = hdr_good_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                byte_cnt_next = '0;
                hdr_good_next = 1'b0;
            end
            else
            begin
                byte_cnt_next = cnt_inc;
                if (byte_cnt_reg == CNT_W'(HDR_BYTES - 1))
                    hdr_good_next = checks_ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            hdr_good_reg <= 1'b0;
        end
        else
        begin
            byte_cnt_reg <= byte_cnt_next;
            hdr_good_reg <= hdr_good_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                hdr_reg[i] <= hdr_eff[i];
            end
        end
    end

    mhd_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .data_a    (item_a),
        .push_b    (push_b),
        .data_b    (item_b),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign s_axis_tready = room;
    assign m_axis_tuser  = head.status;
    assign m_axis_tdata  = {head.payload_byte, head.body_length, head.expiry_seconds,
                            head.service_word, head.node_pair, head.previous_ident,
                            head.thread_ident, head.msg_ident, head.flags,
                            head.msg_type};

endmodule

>>> verif/message_header_deframer_checker.sv
module message_header_deframer_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [215:0] m_axis_tdata,
    input  logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           mismatches,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mhd_pkg::*;

    logic [7:0]       magic_reg;
    logic [7:0]       version_reg;
    logic [15:0]      max_len_reg;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       hdr_store [HDR_BYTES];
    logic             hdr_passed;
    result_t          expected_words [$];

    function automatic logic [15:0] hdr_le16(input int ofs);
        return {hdr_store[ofs + 1], hdr_store[ofs]};
    endfunction

    function automatic logic [31:0] hdr_le32(input int ofs);
        return {hdr_le16(ofs + 2), hdr_le16(ofs)};
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic fin);
        result_t word;
        int      pos;
        pos = byte_count;
        if (pos < HDR_BYTES)
        begin
            hdr_store[pos] = b;
            if (pos == HDR_BYTES - 1)
                hdr_passed = hdr_store[0] == magic_reg && hdr_store[1] == version_reg
                             && hdr_le16(OFS_LEN) <= max_len_reg;
        end
        else if (hdr_passed && byte_count != CNT_MAX && pos - HDR_BYTES < hdr_le16(OFS_LEN))
        begin
            word = '0;
            word.status = ST_PAYLOAD;
            word.payload_byte = b;
            expected_words.push_back(word);
        end
        if (byte_count != CNT_MAX)
            byte_count++;
        if (fin)
        begin
            word = '0;
            if (byte_count < HDR_BYTES)
                word.status = ST_SHORT;
            else if (hdr_store[0] != magic_reg)
                word.status = ST_MAGIC;
            else if (hdr_store[1] != version_reg)
                word.status = ST_VERSION;
            else if (hdr_le16(OFS_LEN) > max_len_reg)
                word.status = ST_TOO_LARGE;
            else if (byte_count < HDR_BYTES + hdr_le16(OFS_LEN))
                word.status = ST_TRUNCATED;
            else
            begin
                word.status         = ST_OK;
                word.msg_type       = hdr_store[OFS_TYPE];
                word.flags          = hdr_store[OFS_FLAGS];
                word.msg_ident      = hdr_le32(OFS_ID);
                word.thread_ident   = hdr_le32(OFS_THREAD);
                word.previous_ident = hdr_le32(OFS_PREV);
                word.node_pair      = {hdr_le16(OFS_SENDER), hdr_le16(OFS_TARGET)};
                word.service_word   = hdr_le32(OFS_SERVICE);
                word.expiry_seconds = hdr_le16(OFS_EXPIRY);
                word.body_length    = hdr_le16(OFS_LEN);
            end
            expected_words.push_back(word);
            byte_count = '0;
            hdr_passed = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word(input result_t got);
        result_t want;
        if (expected_words.size() == 0)
        begin
            $error("unexpected word: status %0d payload_byte %0h", got.status, got.payload_byte);
            mismatches++;
        end
        else
        begin
            want = expected_words.pop_front();
            check_field("status", want.status, got.status);
            check_field("msg_type", want.msg_type, got.msg_type);
            check_field("flags", want.flags, got.flags);
            check_field("msg_ident", want.msg_ident, got.msg_ident);
            check_field("thread_ident", want.thread_ident, got.thread_ident);
            check_field("previous_ident", want.previous_ident, got.previous_ident);
            check_field("node_pair", want.node_pair, got.node_pair);
            check_field("service_word", want.service_word, got.service_word);
            check_field("expiry_seconds", want.expiry_seconds, got.expiry_seconds);
            check_field("body_length", want.body_length, got.body_length);
            check_field("payload_byte", want.payload_byte, got.payload_byte);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   = 8'h00;
            version_reg = 8'h01;
            max_len_reg = 16'd256;
            byte_count  = '0;
            hdr_passed  = 1'b0;
            for (int i = 0; i < HDR_BYTES; i++)
                hdr_store[i] = 8'h00;
            expected_words.delete();
            mismatches  = 0;
            pending     = 0;
        end
        else
        begin
            // outputs first: a word leaving now was predicted on an earlier edge
            if (m_axis_tvalid && m_axis_tready)
                check_word(result_t'({m_axis_tdata, m_axis_tuser}));
            if (s_axis_tvalid && s_axis_tready)
                deframe_byte(s_axis_tdata, s_axis_tlast);
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_MAGIC:       magic_reg   = pwdata[7:0];
                    REG_VERSION:     version_reg = pwdata[7:0];
                    REG_MAX_PAYLOAD: max_len_reg = pwdata[15:0];
                    default:         ;
                endcase
            pending = expected_words.size();
        end
    end

endmodule

>>> verif/tb_message_header_deframer_top.sv
module tb_message_header_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mhd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_BYTES   = 60;
    localparam int MAX_BODY       = 40;

    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic [7:0]   s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tready = 1'b1;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;

    wire          s_axis_tready;
    wire          m_axis_tvalid;
    wire [215:0]  m_axis_tdata;
    wire [2:0]    m_axis_tuser;
    wire [31:0]   prdata;
    wire          pready;

    int           mismatches;
    int           pending;

    bit           calm = 1'b0;
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           stall_left = 0;
    int           bytes_sent = 0;
    int           buffers_sent = 0;
    int           settings = 0;
    logic [7:0]   cur_magic = 8'h00;
    logic [7:0]   cur_version = 8'h01;
    logic [15:0]  cur_max = 16'd256;

    always #(CLK_PERIOD / 2) clk = ~clk;

    message_header_deframer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    message_header_deframer_checker deframer_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // receiver back-pressure; ready returns high between any two stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!m_axis_tready)
            m_axis_tready <= 1'b1;
        else if (!calm && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 15);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), i == n - 1);
        buffers_sent++;
    endtask

    task automatic send_message(input logic [7:0] magic, input logic [7:0] version,
                                input logic [15:0] len, input int body, input fill_t fill);
        logic [7:0] hdr [HDR_BYTES];
        hdr[0] = magic;
        hdr[1] = version;
        for (int i = 2; i < OFS_LEN; i++)
            case (fill)
                FILL_ONES:  hdr[i] = 8'hFF;
                FILL_ZEROS: hdr[i] = 8'h00;
                default:    hdr[i] = 8'($urandom_range(0, 255));
            endcase
        hdr[OFS_LEN]     = len[7:0];
        hdr[OFS_LEN + 1] = len[15:8];
        for (int i = 0; i < HDR_BYTES; i++)
            send_byte(hdr[i], body == 0 && i == HDR_BYTES - 1);
        for (int i = 0; i < body; i++)
            send_byte(8'($urandom_range(0, 255)), i == body - 1);
        buffers_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] magic, input logic [7:0] version,
                             input logic [15:0] max_len);
        drain();
        set_reg(REG_MAGIC, {24'h0, magic});
        set_reg(REG_VERSION, {24'h0, version});
        set_reg(REG_MAX_PAYLOAD, {16'h0, max_len});
        cur_magic   = magic;
        cur_version = version;
        cur_max     = max_len;
        settings++;
    endtask

    task automatic random_setting();
        logic [15:0] max_len;
        case ($urandom_range(0, 3))
            0:       max_len = 16'hFFFF;
            1:       max_len = 16'($urandom_range(0, 16));
            2:       max_len = 16'($urandom_range(0, 65535));
            default: max_len = 16'($urandom_range(17, 80));
        endcase
        configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), max_len);
        gap_pct   = $urandom_range(0, 3) * 20;
        stall_pct = $urandom_range(0, 3) * 20;
    endtask

    task automatic random_buffer();
        int          pick;
        int          room;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        room = (cur_max < MAX_BODY) ? cur_max : MAX_BODY;
        if (pick < 10)
            send_noise($urandom_range(1, HDR_BYTES - 1));
        else if (pick < 17)
            send_message(8'(cur_magic + $urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)), $urandom_range(0, 4), FILL_RANDOM);
        else if (pick < 24)
            send_message(cur_magic, 8'(cur_version + $urandom_range(1, 255)),
                         16'($urandom_range(0, 65535)), $urandom_range(0, 4), FILL_RANDOM);
        else if (pick < 31 && cur_max != 16'hFFFF)
            send_message(cur_magic, cur_version, 16'($urandom_range(cur_max + 1, 65535)),
                         $urandom_range(0, 4), FILL_RANDOM);
        else if (pick < 45 && room > 0)
        begin
            len = 16'($urandom_range(1, room));
            send_message(cur_magic, cur_version, len, $urandom_range(0, len - 1), FILL_RANDOM);
        end
        else
        begin
            len = 16'($urandom_range(0, room));
            send_message(cur_magic, cur_version, len,
                         len + ($urandom_range(0, 1) ? $urandom_range(0, 3) : 0), FILL_RANDOM);
        end
    endtask

    initial
    begin : stimulus
        int random_start;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values: magic 0, version 1, max 256
        send_noise(1);
        send_noise(HDR_BYTES - 1);
        send_message(8'h00, 8'h01, 16'd0, 0, FILL_ONES);
        send_message(8'h00, 8'h01, 16'd3, 3, FILL_ZEROS);
        send_message(8'h00, 8'h01, 16'd2, 5, FILL_RANDOM);
        send_message(8'h80, 8'hFE, 16'hFFFF, 2, FILL_RANDOM);
        send_message(8'h00, 8'hFE, 16'hFFFF, 1, FILL_RANDOM);
        send_message(8'h00, 8'h01, 16'd257, 2, FILL_RANDOM);
        send_message(8'h00, 8'h01, 16'd10, 4, FILL_RANDOM);
        send_message(8'h00, 8'h01, 16'd256, 0, FILL_ONES);

        drain();
        set_reg(REG_SPARE, 32'hFFFF_FFFF);
        configure(8'hFF, 8'hFF, 16'hFFFF);
        send_message(8'hFF, 8'hFF, 16'hFFFF, 0, FILL_ONES);
        send_message(8'hFF, 8'hFF, 16'd5, 5, FILL_ZEROS);
        configure(8'h00, 8'h00, 16'd0);
        send_message(8'h00, 8'h00, 16'd0, 3, FILL_RANDOM);
        send_message(8'h00, 8'h00, 16'd1, 1, FILL_RANDOM);

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            random_setting();
            repeat ($urandom_range(2, 5)) random_buffer();
        end

        // calm tail, no idling on either side
        calm = 1'b1;
        repeat (2) random_buffer();

        drain();
        $display("covered %0d buffers, %0d bytes, %0d register settings incl. extremes",
                 buffers_sent, bytes_sent, settings);
        $display("every verdict code, surplus and truncated payload, random idling");
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
